>>> hw/rtl/romap_pkg.sv
// Shared types and constants for the ROM overlay automap mapper.
`default_nettype none
package romap_pkg;

	typedef enum logic [1:0] {
		CMD_CTRL_WR = 2'd0,
		CMD_OP_FETCH = 2'd1,
		CMD_M1_FETCH = 2'd2,
		CMD_MEM_WR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MAP_ROM = 2'd0,
		MAP_EEPROM_RAM = 2'd1,
		MAP_RAM3_RAM = 2'd2,
		MAP_TWOBANK = 2'd3
	} map_t;

	localparam int unsigned CTL_CONMEM_BIT = 7;
	localparam int unsigned CTL_MAPRAM_BIT = 6;
	localparam logic [7:0] CTL_MAPRAM_MASK = 8'h40;
	localparam logic [1:0] BANK_RAM3 = 2'd3;
	localparam logic [7:0] AUTOMAP_PAGE = 8'h3D;
	localparam logic [12:0] EXIT_WINDOW = 13'h03FF; // 0x1FF8..0x1FFF, address bits 15..3

	typedef struct packed {
		logic [7:0] control_value;
		map_t current_map;
		logic automap;
		logic twobank_we;
		logic eeprom_dirty;
	} map_state_t;

	typedef struct packed {
		map_t map_state;
		logic [1:0] low_ram_bank;
		logic [1:0] high_ram_bank;
		logic write_hit;
		logic write_to_eeprom;
		logic [1:0] write_bank;
		logic [12:0] write_offset;
		logic eeprom_modified;
	} map_result_t;

endpackage
`default_nettype wire

>>> hw/rtl/romap_step.sv
// Next-state and result logic for one bus event.
`default_nettype none
module romap_step (
	input  wire romap_pkg::map_state_t  cur,
	input  wire                         jumper,
	input  wire romap_pkg::cmd_t        command,
	input  wire [15:0]                  address,
	input  wire [7:0]                   data_byte,
	output romap_pkg::map_state_t       nxt,
	output romap_pkg::map_result_t      res
);

	logic            automap_nxt;
	logic            entry_hit;
	romap_pkg::map_t remapped;
	logic [1:0]      bank;
	logic            bbit;
	logic            low_half;
	logic            in_window;

	assign entry_hit = (address == 16'h0000) || (address == 16'h0008) ||
		(address == 16'h0038) || (address == 16'h0066) ||
		(address == 16'h04C6) || (address == 16'h0562);
	assign bank = cur.control_value[1:0];
	assign low_half = !address[13];
	assign in_window = (address[15:14] == 2'b00);

	always_comb begin
		automap_nxt = cur.automap;
		unique case (command)
			romap_pkg::CMD_OP_FETCH: begin
				if (address[15:8] == romap_pkg::AUTOMAP_PAGE) automap_nxt = 1'b1;
			end
			romap_pkg::CMD_M1_FETCH: begin
				if (entry_hit) automap_nxt = 1'b1;
				if (address[15:3] == romap_pkg::EXIT_WINDOW) automap_nxt = 1'b0;
			end
			default: automap_nxt = cur.automap;
		endcase
	end

	always_comb begin
		priority if (cur.control_value[romap_pkg::CTL_CONMEM_BIT]) begin
			remapped = romap_pkg::MAP_EEPROM_RAM;
		end else if (cur.control_value[romap_pkg::CTL_MAPRAM_BIT]) begin
			if (!jumper && (bank > 2'd1 || cur.current_map == romap_pkg::MAP_TWOBANK))
				remapped = romap_pkg::MAP_TWOBANK;
			else
				remapped = automap_nxt ? romap_pkg::MAP_RAM3_RAM : romap_pkg::MAP_ROM;
		end else if (jumper) begin
			remapped = automap_nxt ? romap_pkg::MAP_EEPROM_RAM : romap_pkg::MAP_ROM;
		end else begin
			remapped = romap_pkg::MAP_ROM;
		end
	end

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (command)
			romap_pkg::CMD_CTRL_WR: begin
				nxt.control_value = data_byte | (cur.control_value & romap_pkg::CTL_MAPRAM_MASK);
				nxt.twobank_we = data_byte[romap_pkg::CTL_MAPRAM_BIT];
			end
			romap_pkg::CMD_OP_FETCH, romap_pkg::CMD_M1_FETCH: begin
				nxt.automap = automap_nxt;
				nxt.current_map = remapped;
			end
			romap_pkg::CMD_MEM_WR: begin
				if (in_window) begin
					unique case (cur.current_map)
						romap_pkg::MAP_EEPROM_RAM: begin
							if (low_half) begin
								if (!jumper) begin
									res.write_hit = 1'b1;
									res.write_to_eeprom = 1'b1;
									nxt.eeprom_dirty = 1'b1;
								end
							end else begin
								res.write_hit = 1'b1;
								res.write_bank = bank;
							end
						end
						romap_pkg::MAP_RAM3_RAM: begin
							if (!low_half && bank != romap_pkg::BANK_RAM3) begin
								res.write_hit = 1'b1;
								res.write_bank = bank;
							end
						end
						romap_pkg::MAP_TWOBANK: begin
							if (cur.twobank_we) begin
								res.write_hit = 1'b1;
								res.write_bank = {cur.control_value[0], !low_half};
							end
						end
						default: res.write_hit = 1'b0;
					endcase
				end
			end
			default: nxt = cur;
		endcase
		if (res.write_hit) res.write_offset = address[12:0];

		// bank selects follow the state after this event
		bbit = nxt.control_value[0];
		res.map_state = nxt.current_map;
		unique case (nxt.current_map)
			romap_pkg::MAP_EEPROM_RAM: res.high_ram_bank = nxt.control_value[1:0];
			romap_pkg::MAP_RAM3_RAM: begin
				res.low_ram_bank = romap_pkg::BANK_RAM3;
				res.high_ram_bank = nxt.control_value[1:0];
			end
			romap_pkg::MAP_TWOBANK: begin
				res.low_ram_bank = {bbit, 1'b0};
				res.high_ram_bank = {bbit, 1'b1};
			end
			default: res.low_ram_bank = 2'd0;
		endcase
		res.eeprom_modified = nxt.eeprom_dirty;
	end

endmodule
`default_nettype wire

>>> hw/rtl/rom_overlay_automap_mapper.sv
// Top level of the ROM overlay automap mapper: input stage, mapper state, result register.
//  channel | dir | signals                                | use
//  s_*     | in  | s_tvalid s_tready s_tdata s_tuser      | bus events
//  m_*     | out | m_tvalid m_tready m_tdata              | map state and write target
//  cfg_*   | in  | cfg_we cfg_wdata                       | protect jumper register
// One event per cycle sustained while m_tready stays high.
// The path is the input register, the step logic and the state/result registers.
// The result register frees the input stage as soon as the downstream side takes a transfer.
// arst_n clears the state to original ROM and sets the jumper (closed).
`default_nettype none
module rom_overlay_automap_mapper (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [23:0] s_tdata,   // address[15:0], data_byte[23:16]
	input  wire [1:0]  s_tuser,   // command[1:0]
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [23:0] m_tdata,  // map_state[1:0], low_ram_bank[3:2], high_ram_bank[5:4],
	                              // write_hit[6], write_to_eeprom[7], write_bank[9:8],
	                              // write_offset[22:10], eeprom_modified[23]
	input  wire        cfg_we,
	input  wire        cfg_wdata
);

	logic                    valid_s1;
	romap_pkg::cmd_t         cmd_s1;
	logic [15:0]             addr_s1;
	logic [7:0]              data_s1;
	logic                    jumper_q;
	romap_pkg::map_state_t   state_q;
	romap_pkg::map_state_t   state_nxt;
	romap_pkg::map_result_t  res_nxt;
	romap_pkg::map_result_t  res_q;
	logic                    out_valid_q;
	logic                    adv;

	assign adv = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= romap_pkg::cmd_t'(s_tuser);
			addr_s1 <= s_tdata[15:0];
			data_s1 <= s_tdata[23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jumper_q <= 1'b1;
		end else if (cfg_we) begin
			jumper_q <= cfg_wdata;
		end
	end

	romap_step u_step (
		.cur       (state_q),
		.jumper    (jumper_q),
		.command   (cmd_s1),
		.address   (addr_s1),
		.data_byte (data_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				state_q <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= res_nxt;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {res_q.eeprom_modified, res_q.write_offset, res_q.write_bank,
		res_q.write_to_eeprom, res_q.write_hit, res_q.high_ram_bank, res_q.low_ram_bank,
		res_q.map_state};

`ifndef NO_ASSERTIONS
	a_dirty_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(state_q.eeprom_dirty))
		else $error("eeprom dirty flag cleared");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> $stable(state_q))
		else $error("mapper state moved while result stalled");

	a_twobank_banks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.map_state == romap_pkg::MAP_TWOBANK |->
		!res_q.low_ram_bank[0] && res_q.high_ram_bank[0])
		else $error("two-bank layout with wrong bank pairing");

	a_eeprom_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.write_to_eeprom |->
		res_q.write_hit && res_q.eeprom_modified &&
		res_q.map_state == romap_pkg::MAP_EEPROM_RAM)
		else $error("eeprom write outside eeprom layout");

	a_miss_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.write_hit |-> res_q.write_offset == 13'd0 &&
		res_q.write_bank == 2'd0)
		else $error("refused write carries a target");
`endif

endmodule
`default_nettype wire
